// ===== rtl/core/mlpq_pkg.sv =====
// Shared types and constants of the multi-level priority FIFO.
package mlpq_pkg;

    localparam int MAX_LEVELS = 8;
    localparam int FIFO_DEPTH = 16;  // power of two
    localparam int DATA_WIDTH = 32;

    localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int CNT_W  = PTR_W + 1;
    localparam int ADDR_W = LVL_W + PTR_W;
    localparam int NUM_W  = 4;
    localparam int FLD_LVL_W = 4;
    localparam int FLD_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_NUM_LEVELS = 1'b0;

    typedef logic [2:0] t_status;

    localparam t_status ST_ENQ   = 3'd0;
    localparam t_status ST_DEQ   = 3'd1;
    localparam t_status ST_OVF   = 3'd2;
    localparam t_status ST_INV   = 3'd3;
    localparam t_status ST_EMPTY = 3'd4;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef struct packed {
        logic                 wr_en;
        logic                 rd_en;
        logic [ADDR_W-1:0]    addr;
        t_status              status;
        logic [FLD_LVL_W-1:0] served;
        logic                 all_empty;
    } t_op;

endpackage

// ===== rtl/core/mlpq_ctrl.sv =====
// Per-level head and fill counters with enqueue check and dequeue priority select.
module mlpq_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_req_type,
    input  logic [mlpq_pkg::FLD_LVL_W-1:0] i_level,
    input  logic [mlpq_pkg::NUM_W-1:0]     i_num_used,
    output mlpq_pkg::t_op                  o_op
);
    import mlpq_pkg::*;

    logic [PTR_W-1:0] r_head [MAX_LEVELS];
    logic [CNT_W-1:0] r_fill [MAX_LEVELS];
    logic [PTR_W-1:0] n_head [MAX_LEVELS];
    logic [CNT_W-1:0] n_fill [MAX_LEVELS];

    logic [MAX_LEVELS-1:0] in_use;
    logic [MAX_LEVELS-1:0] busy;
    logic                  lvl_ok;
    logic [LVL_W-1:0]      q;
    logic                  found;
    logic [LVL_W-1:0]      sel;
    logic [PTR_W-1:0]      tail;

    always_comb begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
            in_use[i] = (NUM_W+1)'(i) < {1'b0, i_num_used};
            busy[i]   = in_use[i] && (r_fill[i] != '0);
        end
        lvl_ok = (i_level != '0) && (i_level <= i_num_used);
        q      = LVL_W'(i_level - FLD_LVL_W'(1));
        tail   = r_head[q] + r_fill[q][PTR_W-1:0];
        found  = 1'b0;
        sel    = '0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if (busy[i] && !found) begin
                found = 1'b1;
                sel   = LVL_W'(i);
            end
        end

        o_op.wr_en  = 1'b0;
        o_op.rd_en  = 1'b0;
        o_op.addr   = {q, tail};
        o_op.served = '0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            n_head[i] = r_head[i];
            n_fill[i] = r_fill[i];
        end

        if (i_req_type == REQ_ENQ) begin
            if (!lvl_ok) begin
                o_op.status = ST_INV;
            end else if (r_fill[q] == CNT_W'(FIFO_DEPTH)) begin
                o_op.status = ST_OVF;
            end else begin
                o_op.status = ST_ENQ;
                o_op.wr_en  = i_accept;
                n_fill[q]   = r_fill[q] + CNT_W'(1);
            end
        end else begin
            if (found) begin
                o_op.status = ST_DEQ;
                o_op.rd_en  = i_accept;
                o_op.addr   = {sel, r_head[sel]};
                o_op.served = FLD_LVL_W'(sel) + FLD_LVL_W'(1);
                n_head[sel] = r_head[sel] + PTR_W'(1);
                n_fill[sel] = r_fill[sel] - CNT_W'(1);
            end else begin
                o_op.status = ST_EMPTY;
            end
        end

        o_op.all_empty = 1'b1;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if (in_use[i] && (n_fill[i] != '0)) begin
                o_op.all_empty = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_head[i] <= '0;
                r_fill[i] <= '0;
            end
        end else if (i_accept) begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_head[i] <= n_head[i];
                r_fill[i] <= n_fill[i];
            end
        end
    end

endmodule

// ===== rtl/core/mlpq_mem.sv =====
// Entry storage for all levels, one write or one registered read per cycle.
module mlpq_mem (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  logic                            i_rd_en,
    input  logic [mlpq_pkg::ADDR_W-1:0]     i_addr,
    input  logic [mlpq_pkg::DATA_WIDTH-1:0] i_wr_data,
    output logic [mlpq_pkg::DATA_WIDTH-1:0] o_rd_data
);
    import mlpq_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [MAX_LEVELS*FIFO_DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/multi_level_priority_fifo.sv =====
// Top level of the strict priority multi-queue: config register, control, storage, result stage.
// One request (enqueue or dequeue) is taken per cycle; its result is shown the next cycle
// from the result register, along with the dequeued data from the registered memory read port.
// A new request is taken whenever the result register is empty or is being drained in the same
// cycle, so it sustains one transfer per cycle while i_out_ready is high. num_levels (address 0)
// resets to 2, is clamped to 8, and should be written only while no request is in flight.
module multi_level_priority_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_req_type,
    input  logic [mlpq_pkg::FLD_DATA_W-1:0]  i_data_in,
    input  logic [mlpq_pkg::FLD_LVL_W-1:0]   i_level,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [mlpq_pkg::FLD_DATA_W-1:0]  o_data_out,
    output logic [2:0]                       o_status,
    output logic [mlpq_pkg::FLD_LVL_W-1:0]   o_served_level,
    output logic                             o_all_empty
);
    import mlpq_pkg::*;

    logic [NUM_W-1:0]     r_num_levels;
    logic [NUM_W-1:0]     num_used;
    logic                 accept;
    t_op                  op;
    logic [DATA_WIDTH-1:0] rd_data;

    logic                 r_out_valid;
    logic                 r_deq;
    t_status              r_status;
    logic [FLD_LVL_W-1:0] r_served;
    logic                 r_all_empty;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NUM_LEVELS) ? {{(32-NUM_W){1'b0}}, r_num_levels} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_levels <= NUM_W'(2);
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_NUM_LEVELS) begin
            r_num_levels <= pwdata[NUM_W-1:0];
        end
    end

    assign num_used = ({1'b0, r_num_levels} > (NUM_W+1)'(MAX_LEVELS)) ?
                      NUM_W'(MAX_LEVELS) : r_num_levels;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    mlpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (i_req_type),
        .i_level    (i_level),
        .i_num_used (num_used),
        .o_op       (op)
    );

    mlpq_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (op.wr_en),
        .i_rd_en   (op.rd_en),
        .i_addr    (op.addr),
        .i_wr_data (i_data_in[DATA_WIDTH-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_deq       <= op.rd_en;
            r_status    <= op.status;
            r_served    <= op.served;
            r_all_empty <= op.all_empty;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_data_out     = r_deq ? FLD_DATA_W'(rd_data) : '0;
    assign o_status       = r_status;
    assign o_served_level = r_served;
    assign o_all_empty    = r_all_empty;

`ifndef SYNTHESIS
    a_no_data_unless_deq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_DEQ |-> o_data_out == '0 && o_served_level == '0)
        else $error("data or level shown on a non-dequeue result");

    a_served_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_DEQ |->
            o_served_level != '0 && o_served_level <= FLD_LVL_W'(MAX_LEVELS))
        else $error("served level out of range");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_all_empty)
        else $error("empty dequeue without all_empty");

    a_enq_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_ENQ |-> !o_all_empty)
        else $error("all_empty after a successful enqueue");
`endif

endmodule

// ===== dv/tb_multi_level_priority_fifo.sv =====
// Self-checking testbench for the multi-level priority FIFO: directed and random traffic.
module tb_multi_level_priority_fifo;
    import mlpq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_SETTING = 50;

    typedef struct {
        logic [FLD_DATA_W-1:0] data_out;
        t_status               status;
        logic [FLD_LVL_W-1:0]  served_level;
        logic                  all_empty;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_req_type = REQ_ENQ;
    logic [FLD_DATA_W-1:0] i_data_in = '0;
    logic [FLD_LVL_W-1:0]  i_level = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [FLD_DATA_W-1:0] o_data_out;
    logic [2:0]            o_status;
    logic [FLD_LVL_W-1:0]  o_served_level;
    logic                  o_all_empty;

    // predictor state
    logic [DATA_WIDTH-1:0] queue_slots [MAX_LEVELS][FIFO_DEPTH];
    int unsigned           queue_head [MAX_LEVELS];
    int unsigned           queue_fill [MAX_LEVELS];
    logic [NUM_W-1:0]      levels_setting;

    t_result pending_results[$];
    int      fail_count = 0;
    int      cycle_count = 0;

    int hold_request = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int mode_cycles = 0;

    multi_level_priority_fifo u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_data_in      (i_data_in),
        .i_level        (i_level),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_data_out     (o_data_out),
        .o_status       (o_status),
        .o_served_level (o_served_level),
        .o_all_empty    (o_all_empty)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int unsigned active_levels();
        return (levels_setting > MAX_LEVELS) ? MAX_LEVELS : levels_setting;
    endfunction

    function automatic t_result predict_request(logic req, logic [FLD_DATA_W-1:0] data,
                                                logic [FLD_LVL_W-1:0] lvl);
        t_result     r;
        int unsigned used;
        int unsigned q;
        logic        found;
        used = active_levels();
        r.data_out = '0;
        r.served_level = '0;
        r.status = ST_EMPTY;
        if (req == REQ_ENQ) begin
            if (lvl == 0 || lvl > used) begin
                r.status = ST_INV;
            end else begin
                q = lvl - 1;
                if (queue_fill[q] >= FIFO_DEPTH) begin
                    r.status = ST_OVF;
                end else begin
                    queue_slots[q][(queue_head[q] + queue_fill[q]) % FIFO_DEPTH] = data;
                    queue_fill[q]++;
                    r.status = ST_ENQ;
                end
            end
        end else begin
            found = 1'b0;
            for (int i = 0; i < used; i++) begin
                if (!found && queue_fill[i] != 0) begin
                    found = 1'b1;
                    r.data_out = queue_slots[i][queue_head[i]];
                    queue_head[i] = (queue_head[i] + 1) % FIFO_DEPTH;
                    queue_fill[i]--;
                    r.served_level = FLD_LVL_W'(i + 1);
                    r.status = ST_DEQ;
                end
            end
        end
        r.all_empty = 1'b1;
        for (int i = 0; i < used; i++)
            if (queue_fill[i] != 0)
                r.all_empty = 1'b0;
        return r;
    endfunction

    // receiver: changing stall pattern plus on-demand long hold-off
    always @(posedge i_clk) begin
        mode_cycles++;
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (mode_cycles >= 48) begin
            mode_cycles = 0;
            stall_mode = $urandom_range(0, 2);
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: begin
                    i_out_ready <= 1'b1;
                end
                1: begin
                    i_out_ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    i_out_ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    // result checker: a transfer at the next rising edge is certain at the falling edge
    always @(negedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: data_out %h status %0d", o_data_out,
                       o_status);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_data_out !== exp_r.data_out) begin
                    $error("data_out mismatch: expected %h, got %h", exp_r.data_out,
                           o_data_out);
                    fail_count++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status mismatch: expected %0d, got %0d", exp_r.status, o_status);
                    fail_count++;
                end
                if (o_served_level !== exp_r.served_level) begin
                    $error("served_level mismatch: expected %0d, got %0d",
                           exp_r.served_level, o_served_level);
                    fail_count++;
                end
                if (o_all_empty !== exp_r.all_empty) begin
                    $error("all_empty mismatch: expected %0b, got %0b", exp_r.all_empty,
                           o_all_empty);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_request(logic req, logic [FLD_DATA_W-1:0] data,
                                logic [FLD_LVL_W-1:0] lvl);
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_data_in <= data;
        i_level <= lvl;
        forever begin
            @(negedge i_clk);
            if (o_in_ready)
                break;
        end
        @(posedge i_clk);
        pending_results.push_back(predict_request(req, data, lvl));
    endtask

    task automatic pause_sender(int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_num_levels(logic [NUM_W-1:0] value);
        drain_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_NUM_LEVELS, 2'b00};
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        levels_setting = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [FLD_DATA_W-1:0] pick_data();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [FLD_LVL_W-1:0] pick_level();
        int unsigned sel;
        int unsigned used;
        sel = $urandom_range(0, 9);
        used = active_levels();
        if (sel == 0)
            return '0;
        if (sel == 1 || used == 0)
            return FLD_LVL_W'($urandom_range(0, 15));
        return FLD_LVL_W'($urandom_range(1, used));
    endfunction

    task automatic test_reset_state();
        send_request(REQ_DEQ, 32'h1234_5678, 4'd1);
        send_request(REQ_ENQ, 32'hDEAD_BEEF, 4'd0);
        send_request(REQ_ENQ, 32'hCAFE_F00D, 4'd3);
        send_request(REQ_ENQ, 32'h0BAD_CAFE, 4'd15);
        send_request(REQ_ENQ, 32'hFFFF_FFFF, 4'd2);
        send_request(REQ_ENQ, 32'h0000_0000, 4'd1);
        send_request(REQ_DEQ, '0, 4'd0);
        send_request(REQ_DEQ, '1, 4'd15);
        send_request(REQ_DEQ, '0, 4'd0);
    endtask

    task automatic test_zero_levels();
        write_num_levels(4'd0);
        send_request(REQ_ENQ, 32'h1111_2222, 4'd1);
        send_request(REQ_DEQ, '0, 4'd0);
    endtask

    task automatic test_clamped_levels();
        write_num_levels(4'd15);
        send_request(REQ_ENQ, 32'hA5A5_A5A5, 4'd8);
        send_request(REQ_ENQ, 32'h3C3C_3C3C, 4'd9);
        send_request(REQ_ENQ, 32'h5A5A_5A5A, 4'd1);
    endtask

    task automatic test_hidden_levels();
        write_num_levels(4'd1);
        send_request(REQ_DEQ, '0, 4'd0);
        send_request(REQ_DEQ, '0, 4'd0);
        write_num_levels(4'd8);
        send_request(REQ_DEQ, '0, 4'd0);
    endtask

    task automatic test_backpressure();
        write_num_levels(4'd4);
        hold_request = 200;
        for (int i = 0; i < 40; i++)
            send_request(($urandom_range(0, 9) < 7) ? REQ_ENQ : REQ_DEQ, pick_data(),
                         pick_level());
        drain_results();
    endtask

    task automatic test_random_traffic();
        logic [NUM_W-1:0] settings [8];
        int unsigned      enq_pct;
        int unsigned      burst_left;
        int unsigned      gap;
        settings = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd5, 4'd2, 4'd8};
        burst_left = 0;
        for (int p = 0; p < 8; p++) begin
            write_num_levels(settings[p]);
            enq_pct = (p == 0) ? 85 : $urandom_range(30, 80);
            for (int i = 0; i < RANDOM_PER_SETTING; i++) begin
                if (burst_left == 0) begin
                    gap = $urandom_range(0, 6);
                    if (gap != 0)
                        pause_sender(gap);
                    burst_left = $urandom_range(1, 12);
                end
                burst_left--;
                send_request(($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ,
                             pick_data(), pick_level());
            end
        end
    endtask

    initial begin
        levels_setting = 4'd2;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            queue_head[i] = 0;
            queue_fill[i] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_zero_levels();
        test_clamped_levels();
        test_hidden_levels();
        test_backpressure();
        test_random_traffic();
        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
